// File: sv/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned ADDR_BITS      = 32;
  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  localparam int unsigned REQ_W    = 17;
  localparam int unsigned ALIGN_W  = 5;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned BLOCKS_W = 11;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned REGSEL_W = PADDR_W - 2;

  localparam logic [ADDR_BITS-1:0] BASE_RST   = ADDR_BITS'(65536);
  localparam logic [SHIFT_W-1:0]   SHIFT_RST  = SHIFT_W'(3);
  localparam logic [SHIFT_W-1:0]   SHIFT_MIN  = SHIFT_W'(3);
  localparam logic [SHIFT_W-1:0]   SHIFT_MAX  = SHIFT_W'(16);
  localparam logic [BLOCKS_W-1:0]  BLOCKS_RST = BLOCKS_W'(1024);

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_POOL_RESET = 2'd2,
    OP_NOP        = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EXHAUSTED     = 3'd1,
    ST_TOO_LARGE     = 3'd2,
    ST_MISALIGNED    = 3'd3,
    ST_OUT_OF_BOUNDS = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_POP,
    FSM_WALK
  } fsm_e;

  typedef enum logic [REGSEL_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BLOCK_SHIFT  = 2'd1,
    REG_POOL_BLOCKS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [REQ_W-1:0]     request_bytes;
    logic [ALIGN_W-1:0]   align_shift;
    logic [ADDR_BITS-1:0] address;
  } fbpa_req_t;

  typedef struct packed {
    status_e              status;
    logic [ADDR_BITS-1:0] block_address;
    logic                 pool_empty;
  } fbpa_rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] base_address;
    logic [SHIFT_W-1:0]   block_shift;
    logic [BLOCKS_W-1:0]  pool_blocks;
  } fbpa_cfg_t;

endpackage

// File: sv/fbpa_list_ram.sv
// Next-index memory of the free list: one write port, one registered read port.
module fbpa_list_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] ram_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ram_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= ram_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/fbpa_cfg_regs.sv
// APB configuration registers: pool base address, block shift and pool size.
module fbpa_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output fbpa_pkg::fbpa_cfg_t          cfg_o
);
  import fbpa_pkg::*;

  logic [ADDR_BITS-1:0] base_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [BLOCKS_W-1:0]  blocks_q;
  logic                 wr_en;
  cfg_reg_e             reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RST;
      shift_q  <= SHIFT_RST;
      blocks_q <= BLOCKS_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE_ADDRESS: base_q   <= pwdata[ADDR_BITS-1:0];
        REG_BLOCK_SHIFT:  shift_q  <= pwdata[SHIFT_W-1:0];
        REG_POOL_BLOCKS:  blocks_q <= pwdata[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE_ADDRESS: prdata = PDATA_W'(base_q);
      REG_BLOCK_SHIFT:  prdata = PDATA_W'(shift_q);
      REG_POOL_BLOCKS:  prdata = PDATA_W'(blocks_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = '{base_address: base_q, block_shift: shift_q, pool_blocks: blocks_q};

endmodule

// File: sv/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: control sequencer, list head and result register.
//
// The pool is a run of equal blocks of 2^block_shift bytes starting at base_address; free
// blocks form a last-in first-out list kept as a next-index memory plus a head register.
// Every request returns exactly one response. An allocate checks the head and issues the read
// of its next index, then takes that index from the registered read port of the memory into
// the head. A free, a no-operation or a failed allocate takes the request, then executes. A
// pool reset walks the next-index memory one entry per cycle. A new request is taken only in
// the idle state or while an allocate advances the head. After hardware reset the same walk
// runs over min(1024, MAX_BLOCKS) entries while in_ready_o is low; configuration writes are
// taken during it. The response register decouples the two sides: a request can be taken
// while the previous response still waits for out_ready_i. Double frees are not detected, and
// register writes do not re-thread the list.
module fixed_block_pool_allocator_core #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fbpa_pkg::fbpa_req_t          in_req_i,
  // response channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fbpa_pkg::fbpa_rsp_t          out_rsp_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
  input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
  output logic [fbpa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import fbpa_pkg::*;

  // Index width holds the end mark (MAX_BLOCKS); memory address covers the blocks only.
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW     = $clog2(MAX_BLOCKS);
  localparam int unsigned SPAN_W = ADDR_BITS + 2;
  localparam int unsigned LIM_W  = REQ_W + 1;
  localparam int unsigned RST_BLOCKS_INT =
    (MAX_BLOCKS < int'(BLOCKS_RST)) ? MAX_BLOCKS : int'(BLOCKS_RST);
  localparam logic [IDX_W-1:0] LIST_END   = IDX_W'(MAX_BLOCKS);
  localparam logic [IDX_W-1:0] RST_BLOCKS = IDX_W'(RST_BLOCKS_INT);

  fbpa_cfg_t cfg;

  // control state
  fsm_e             state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;        // walk position of the re-thread
  logic [IDX_W-1:0] walk_n_q, walk_n_d;  // blocks to thread in this walk
  logic             walk_rsp_q, walk_rsp_d;
  logic             out_valid_q, out_valid_d;

  // payload
  fbpa_req_t            req_q;
  fbpa_rsp_t            rsp_q, rsp_d;
  logic [ADDR_BITS-1:0] pend_addr_q, pend_addr_d;
  logic                 rsp_load;

  // memory port
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [IDX_W-1:0] mem_wdata, mem_rdata;

  // effective configuration
  logic [SHIFT_W-1:0] eff_shift;
  logic [IDX_W-1:0]   eff_blocks;

  // request checks
  logic [ADDR_BITS-1:0] head_addr;
  logic [ADDR_BITS-1:0] align_mask;
  logic [LIM_W-1:0]     size_limit;
  logic [SPAN_W-1:0]    pool_lo, pool_hi, free_addr_w;
  logic [ADDR_BITS-1:0] free_off;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     cnt_inc;
  logic                 too_large, exhausted, misaligned, out_of_bounds, null_free;
  logic                 slot_free, walk_last;

  fbpa_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbpa_list_ram #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (IDX_W)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clamp the block shift to 3..16 and the pool size to 1..MAX_BLOCKS.
  always_comb begin
    if (cfg.block_shift < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (cfg.block_shift > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = cfg.block_shift;
    end
  end

  always_comb begin
    if (cfg.pool_blocks == '0) begin
      eff_blocks = IDX_W'(1);
    end else if (32'(cfg.pool_blocks) > MAX_BLOCKS) begin
      eff_blocks = LIST_END;
    end else begin
      eff_blocks = IDX_W'(cfg.pool_blocks);
    end
  end

  // Allocate checks against the current head; addresses wrap modulo 2^ADDR_BITS.
  assign head_addr  = cfg.base_address + (ADDR_BITS'(head_q) << eff_shift);
  assign size_limit = LIM_W'(1) << eff_shift;
  assign align_mask = ~({ADDR_BITS{1'b1}} << req_q.align_shift);
  assign too_large  = LIM_W'(req_q.request_bytes) > size_limit;
  assign exhausted  = head_q >= LIST_END;
  assign misaligned = |(head_addr & align_mask);

  // Free checks: bounds are computed without wrap, two extra bits of headroom.
  assign pool_lo       = SPAN_W'(cfg.base_address);
  assign pool_hi       = pool_lo + (SPAN_W'(eff_blocks) << eff_shift);
  assign free_addr_w   = SPAN_W'(req_q.address);
  assign null_free     = req_q.address == '0;
  assign out_of_bounds = (free_addr_w < pool_lo) || (free_addr_w >= pool_hi);
  assign free_off      = req_q.address - cfg.base_address;
  assign free_idx      = IDX_W'(free_off >> eff_shift);

  assign cnt_inc   = cnt_q + IDX_W'(1);
  assign walk_last = cnt_inc == walk_n_q;

  // The response register may be reloaded when it is empty or drains this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    walk_n_d    = walk_n_q;
    walk_rsp_d  = walk_rsp_q;
    pend_addr_d = pend_addr_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = head_q[AW-1:0];
    rsp_load    = 1'b0;
    rsp_d       = '{status: ST_OK, block_address: '0, pool_empty: exhausted};

    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        // Hold the request until the response register has room.
        if (slot_free) begin
          case (req_q.opcode)
            OP_ALLOC: begin
              if (too_large) begin
                rsp_d.status = ST_TOO_LARGE;
                rsp_load     = 1'b1;
                state_d      = FSM_IDLE;
              end else if (exhausted) begin
                rsp_d.status = ST_EXHAUSTED;
                rsp_load     = 1'b1;
                state_d      = FSM_IDLE;
              end else if (misaligned) begin
                rsp_d.status = ST_MISALIGNED;
                rsp_load     = 1'b1;
                state_d      = FSM_IDLE;
              end else begin
                // Pop: fetch the successor of the head.
                mem_re      = 1'b1;
                pend_addr_d = head_addr;
                state_d     = FSM_POP;
              end
            end
            OP_FREE: begin
              if (!null_free) begin
                if (out_of_bounds) begin
                  rsp_d.status = ST_OUT_OF_BOUNDS;
                end else begin
                  // Push: link the freed block in front of the current head.
                  mem_we           = 1'b1;
                  mem_waddr        = free_idx[AW-1:0];
                  mem_wdata        = exhausted ? LIST_END : head_q;
                  head_d           = free_idx;
                  rsp_d.pool_empty = 1'b0;
                end
              end
              rsp_load = 1'b1;
              state_d  = FSM_IDLE;
            end
            OP_POOL_RESET: begin
              cnt_d      = '0;
              walk_n_d   = eff_blocks;
              walk_rsp_d = 1'b1;
              state_d    = FSM_WALK;
            end
            default: begin
              rsp_load = 1'b1;
              state_d  = FSM_IDLE;
            end
          endcase
        end
      end

      FSM_POP: begin
        // Advance the head; the next request may enter in this cycle.
        in_ready_o          = 1'b1;
        head_d              = mem_rdata;
        rsp_d.block_address = pend_addr_q;
        rsp_d.pool_empty    = mem_rdata >= LIST_END;
        rsp_load            = 1'b1;
        state_d             = in_valid_i ? FSM_EXEC : FSM_IDLE;
      end

      FSM_WALK: begin
        // Thread block i to i+1, the last block to the end mark.
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = walk_last ? LIST_END : cnt_inc;
        cnt_d     = cnt_inc;
        if (walk_last) begin
          cnt_d      = '0;
          head_d     = '0;
          walk_rsp_d = 1'b0;
          state_d    = FSM_IDLE;
          if (walk_rsp_q) begin
            rsp_d.pool_empty = 1'b0;
            rsp_load         = 1'b1;
          end
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_WALK;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      walk_n_q    <= RST_BLOCKS;
      walk_rsp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      walk_n_q    <= walk_n_d;
      walk_rsp_q  <= walk_rsp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
    pend_addr_q <= pend_addr_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// File: sv/fbpa_checker.sv
// Port-level checks of the fixed block pool allocator, bound to the top level.
module fbpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input fbpa_pkg::fbpa_rsp_t out_rsp_o
);
  import fbpa_pkg::*;

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // Only a successful allocate carries a block address.
  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |-> out_rsp_o.block_address == '0)
    else $error("failed request reported a block address");

  // An exhausted pool stays empty after the failed allocate.
  a_exhausted_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_EXHAUSTED) |-> out_rsp_o.pool_empty)
    else $error("exhausted status without empty pool");

  // A taken request is executed before the next one is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another executes");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// File: sim/fixed_block_pool_allocator_core_tb.sv
// Self-checking testbench of the fixed block pool allocator core against a free-list predictor.
module fixed_block_pool_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int unsigned POOL_DEPTH  = MAX_BLOCKS_DEF;
  localparam int unsigned LIST_END    = POOL_DEPTH;
  // Longest quiet stretch the block needs: a full re-thread walk plus margin.
  localparam int unsigned WALK_CYCLES = POOL_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_IDLE    = 16;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  fbpa_req_t          in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  fbpa_rsp_t          out_rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fixed_block_pool_allocator_core #(
    .MAX_BLOCKS(POOL_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: configuration registers, next-index memory and list head.
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] cfg_base;
  logic [SHIFT_W-1:0]   cfg_shift;
  logic [BLOCKS_W-1:0]  cfg_blocks;
  logic [BLOCKS_W-1:0]  link_mem [POOL_DEPTH];
  logic [BLOCKS_W-1:0]  head_idx;

  // Responses owed by the block, oldest first.
  fbpa_rsp_t            due_responses_q[$];
  // Addresses handed out and not yet freed; feeds well-formed free requests.
  logic [ADDR_BITS-1:0] live_addr_q[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          sender_idle;
  bit          receiver_idle;
  int unsigned holdoff_cycles;

  // Clamp the block shift and the pool size the way the hardware does.
  function automatic int unsigned shift_in_use();
    if (cfg_shift < SHIFT_MIN) return SHIFT_MIN;
    if (cfg_shift > SHIFT_MAX) return SHIFT_MAX;
    return cfg_shift;
  endfunction

  function automatic int unsigned blocks_in_use();
    if (cfg_blocks == 0) return 1;
    if (cfg_blocks > POOL_DEPTH) return POOL_DEPTH;
    return cfg_blocks;
  endfunction

  // Byte address of a block from the current registers; wraps at the address width.
  function automatic logic [ADDR_BITS-1:0] block_base(int unsigned idx);
    logic [63:0] sum;
    sum = 64'(cfg_base) + (64'(idx) << shift_in_use());
    return sum[ADDR_BITS-1:0];
  endfunction

  // Thread blocks in index order; the last pool block holds the end mark.
  function automatic void rethread_pool();
    int unsigned n;
    int unsigned i;
    n = blocks_in_use();
    for (i = 0; i + 1 < n; i++) link_mem[i] = BLOCKS_W'(i + 1);
    link_mem[n-1] = BLOCKS_W'(LIST_END);
    head_idx = '0;
  endfunction

  function automatic void reset_model();
    cfg_base   = BASE_RST;
    cfg_shift  = SHIFT_RST;
    cfg_blocks = BLOCKS_RST;
    foreach (link_mem[i]) link_mem[i] = BLOCKS_W'(LIST_END);
    rethread_pool();
  endfunction

  // Advance the predicted allocator by one request and return its response.
  function automatic fbpa_rsp_t apply_allocator_op(fbpa_req_t req);
    fbpa_rsp_t   rsp;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] amask;
    logic [63:0] addr;
    int unsigned sh;
    int unsigned idx;
    sh                = shift_in_use();
    rsp.status        = ST_OK;
    rsp.block_address = '0;
    case (req.opcode)
      OP_ALLOC: begin
        // Size is checked first, then exhaustion, then alignment of the head.
        if (64'(req.request_bytes) > (64'd1 << sh)) begin
          rsp.status = ST_TOO_LARGE;
        end else if (head_idx >= LIST_END) begin
          rsp.status = ST_EXHAUSTED;
        end else begin
          addr  = 64'(block_base(head_idx));
          amask = (64'd1 << req.align_shift) - 64'd1;
          if ((addr & amask) != 0) begin
            rsp.status = ST_MISALIGNED;
          end else begin
            rsp.block_address = addr[ADDR_BITS-1:0];
            head_idx          = link_mem[head_idx];
          end
        end
      end
      OP_FREE: begin
        // A null pointer is dropped silently.
        if (req.address != 0) begin
          lo = 64'(cfg_base);
          hi = lo + (64'(blocks_in_use()) << sh);
          if (64'(req.address) < lo || 64'(req.address) >= hi) begin
            rsp.status = ST_OUT_OF_BOUNDS;
          end else begin
            idx           = int'((64'(req.address) - lo) >> sh);
            link_mem[idx] = (head_idx >= LIST_END) ? BLOCKS_W'(LIST_END) : head_idx;
            head_idx      = BLOCKS_W'(idx);
          end
        end
      end
      OP_POOL_RESET: rethread_pool();
      default: ;
    endcase
    rsp.pool_empty = (head_idx >= LIST_END);
    return rsp;
  endfunction

  function automatic logic [PDATA_W-1:0] register_value(cfg_reg_e sel);
    case (sel)
      REG_BASE_ADDRESS: return cfg_base;
      REG_BLOCK_SHIFT:  return PDATA_W'(cfg_shift);
      default:          return PDATA_W'(cfg_blocks);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run; the limit is many times the slowest legal run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[fixed_block_pool_allocator_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  // Run one setup and one access phase; hold the access until pready.
  task automatic apb_transfer(input cfg_reg_e sel, input logic wr,
                              input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {sel, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_register(input cfg_reg_e sel);
    logic [PDATA_W-1:0] got;
    logic [PDATA_W-1:0] want;
    want = register_value(sel);
    apb_transfer(sel, 1'b0, '0, got);
    if (got !== want) begin
      $display("%0t: register %s read expected %h actual %h", $time, sel.name(), want, got);
      mismatch_count++;
    end
  endtask

  // Write a register, mirror it in the predictor, then read it back.
  task automatic write_register(input cfg_reg_e sel, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] ignored;
    apb_transfer(sel, 1'b1, value, ignored);
    case (sel)
      REG_BASE_ADDRESS: cfg_base = value;
      REG_BLOCK_SHIFT:  cfg_shift = value[SHIFT_W-1:0];
      default:          cfg_blocks = value[BLOCKS_W-1:0];
    endcase
    check_register(sel);
  endtask

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------
  // Offer one request, after a random gap if sender_idle is set; predict its response once it is taken.
  task automatic send_request(input fbpa_req_t req);
    int unsigned gap;
    fbpa_rsp_t   rsp;
    gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    rsp = apply_allocator_op(req);
    due_responses_q.push_back(rsp);
    if (req.opcode == OP_POOL_RESET) begin
      live_addr_q.delete();
    end else if (req.opcode == OP_ALLOC && rsp.status == ST_OK) begin
      live_addr_q.push_back(rsp.block_address);
    end
  endtask

  // Unused fields carry random values so their bits toggle too.
  task automatic send_alloc(input logic [REQ_W-1:0] bytes, input logic [ALIGN_W-1:0] align);
    fbpa_req_t req;
    req.opcode        = OP_ALLOC;
    req.request_bytes = bytes;
    req.align_shift   = align;
    req.address       = $urandom;
    send_request(req);
  endtask

  task automatic send_free(input logic [ADDR_BITS-1:0] addr);
    fbpa_req_t req;
    req.opcode        = OP_FREE;
    req.request_bytes = REQ_W'($urandom);
    req.align_shift   = ALIGN_W'($urandom);
    req.address       = addr;
    send_request(req);
  endtask

  task automatic send_op(input opcode_e op);
    fbpa_req_t req;
    req.opcode        = op;
    req.request_bytes = REQ_W'($urandom);
    req.align_shift   = ALIGN_W'($urandom);
    req.address       = $urandom;
    send_request(req);
  endtask

  // Drop valid and hold off until every owed response has come back.
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (due_responses_q.size() != 0) @(posedge clk_i);
  endtask

  // Let a trailing pool walk finish, then load a new pool setting.
  task automatic set_pool_config(input logic [PDATA_W-1:0] base,
                                 input logic [PDATA_W-1:0] shift,
                                 input logic [PDATA_W-1:0] blocks);
    drain_requests();
    repeat (WALK_CYCLES) @(negedge clk_i);
    write_register(REG_BASE_ADDRESS, base);
    write_register(REG_BLOCK_SHIFT, shift);
    write_register(REG_POOL_BLOCKS, blocks);
  endtask

  // Mostly well-formed traffic: allocates that fit, frees of live blocks.
  // The rest keeps the raw random fields as noise.
  function automatic fbpa_req_t pick_random_request(int unsigned reset_pct);
    fbpa_req_t   req;
    logic [63:0] raw;
    logic [63:0] span;
    int unsigned sh;
    int unsigned roll;
    int unsigned k;
    raw  = {$urandom, $urandom};
    req  = raw[$bits(fbpa_req_t)-1:0];
    sh   = shift_in_use();
    span = 64'(blocks_in_use()) << sh;
    roll = $urandom_range(0, 99);
    if (roll < 48) begin
      req.opcode = OP_ALLOC;
      if ($urandom_range(0, 9) != 0) begin
        req.request_bytes = REQ_W'($urandom_range(0, 1 << sh));
        req.align_shift   = ALIGN_W'($urandom_range(0, sh));
      end
    end else if (roll < 83) begin
      req.opcode = OP_FREE;
      if (live_addr_q.size() != 0 && $urandom_range(0, 4) != 0) begin
        // Free a live block through any byte inside it.
        k           = $urandom_range(0, live_addr_q.size() - 1);
        req.address = live_addr_q[k] + ADDR_BITS'($urandom_range(0, (1 << sh) - 1));
        live_addr_q.delete(k);
      end else if ($urandom_range(0, 1) != 0) begin
        req.address = cfg_base + ADDR_BITS'($urandom_range(0, 32'(span - 64'd1)));
      end
    end else if (roll < 83 + reset_pct) begin
      req.opcode = OP_POOL_RESET;
    end else if (roll < 88 + reset_pct) begin
      req.opcode = OP_NOP;
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, plus a long hold-off on demand.
  // ---------------------------------------------------------------------------
  initial begin : response_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      stall = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (holdoff_cycles != 0) begin
        stall          = holdoff_cycles;
        holdoff_cycles = 0;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every accepted response with the oldest owed one, field by field.
  always @(posedge clk_i) begin : response_check
    fbpa_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_responses_q.size() == 0) begin
        $display("%0t: response with none owed: status %0d address %h empty %b",
                 $time, out_rsp_o.status, out_rsp_o.block_address, out_rsp_o.pool_empty);
        mismatch_count++;
      end else begin
        want = due_responses_q.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_rsp_o.status);
          mismatch_count++;
        end
        if (out_rsp_o.block_address !== want.block_address) begin
          $display("%0t: block_address expected %h actual %h", $time, want.block_address,
                   out_rsp_o.block_address);
          mismatch_count++;
        end
        if (out_rsp_o.pool_empty !== want.pool_empty) begin
          $display("%0t: pool_empty expected %b actual %b", $time, want.pool_empty,
                   out_rsp_o.pool_empty);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  // Read back the reset values while the power-on walk is still running.
  task automatic test_register_defaults();
    check_register(REG_BASE_ADDRESS);
    check_register(REG_BLOCK_SHIFT);
    check_register(REG_POOL_BLOCKS);
  endtask

  task automatic test_directed_cases();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    // Four 16-byte blocks at 0x1000.
    set_pool_config(32'h0000_1000, 4, 4);
    send_op(OP_POOL_RESET);
    send_alloc(16, 4);              // exact block size, aligned: block 0
    send_alloc(17, 0);              // one byte too many
    send_alloc(0, 31);              // block 1 fails the widest alignment
    send_alloc(1, 4);
    send_alloc(16, 0);
    send_alloc(8, 3);               // last block: list runs empty
    send_alloc(4, 0);               // exhausted
    send_alloc(17'h1FFFF, 0);       // size check beats the empty list
    send_free(32'h0000_0000);       // null pointer: ignored
    send_free(32'h0000_0FFF);       // one byte below the pool
    send_free(32'h0000_1040);       // first byte past the pool
    send_free(32'h0000_103F);       // last byte of block 3
    send_alloc(16, 4);              // last in, first out: block 3 again
    send_op(OP_NOP);
    // Top of the address space, shift below range and size above range: addresses wrap.
    set_pool_config(32'hFFFF_FFFF, 0, 32'h7FF);
    send_op(OP_POOL_RESET);
    send_alloc(8, 0);
    send_alloc(8, 0);               // block 1 wraps to address 7
    send_free(32'h0000_0007);       // wrapped address lies below the base
    send_free(32'hFFFF_FFFF);
    // Base zero, shift above range, empty size: one 64 KiB block at address 0.
    set_pool_config(32'h0000_0000, 31, 0);
    send_op(OP_POOL_RESET);
    send_alloc(17'h10000, 16);      // block 0 comes back as address 0
    send_alloc(0, 0);
    send_free(32'h0000_0000);       // stays a null free
    send_free(32'h0001_0000);
  endtask

  // Stall the response side long enough to fill the block and stall its input.
  task automatic test_backpressure();
    set_pool_config(32'h0004_0000, 4, 32);
    sender_idle   = 1'b0;
    receiver_idle = 1'b1;
    send_op(OP_POOL_RESET);
    holdoff_cycles = 300;
    repeat (40) send_request(pick_random_request(0));
    // Pause the sender until the block has emptied out.
    drain_requests();
    receiver_idle = 1'b0;
    repeat (20) send_request(pick_random_request(0));
  endtask

  task automatic run_random_phase(input logic [PDATA_W-1:0] base,
                                  input logic [PDATA_W-1:0] shift,
                                  input logic [PDATA_W-1:0] blocks,
                                  input int unsigned count, input bit fresh_pool,
                                  input bit tx_idle, input bit rx_idle,
                                  input int unsigned reset_pct);
    set_pool_config(base, shift, blocks);
    sender_idle   = tx_idle;
    receiver_idle = rx_idle;
    // Without a pool reset the old list survives the register change.
    live_addr_q.delete();
    if (fresh_pool) send_op(OP_POOL_RESET);
    repeat (count) send_request(pick_random_request(reset_pct));
  endtask

  // Large pools only in a few phases: each pool reset walks the whole pool.
  task automatic test_random_traffic();
    run_random_phase(32'h0002_0000, 3, 8, 220, 1'b1, 1'b1, 1'b1, 3);
    run_random_phase($urandom & 32'hFFFF_FF00, 6, 5, 220, 1'b0, 1'b0, 1'b0, 3);
    run_random_phase(32'h0000_0001, 4, 12, 200, 1'b1, 1'b1, 1'b0, 3);
    run_random_phase(32'hFFFF_F000, 9, 16, 200, 1'b1, 1'b0, 1'b1, 3);
    run_random_phase($urandom, 16, 3, 200, 1'b0, 1'b1, 1'b1, 3);
    run_random_phase(32'h0000_0000, 5, 1, 150, 1'b1, 1'b1, 1'b1, 3);
    run_random_phase($urandom & 32'hFFFF_FFF0, $urandom_range(3, 16), 1024, 200,
                     1'b1, 1'b1, 1'b1, 1);
    run_random_phase($urandom, 2, 0, 150, 1'b1, 1'b0, 0, 4);
    run_random_phase($urandom, 31, 32'h7FF, 150, 1'b0, 1'b1, 1'b1, 1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    holdoff_cycles = 0;
    sender_idle    = 1'b1;
    receiver_idle  = 1'b1;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    reset_model();
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_defaults();
    test_directed_cases();
    test_backpressure();
    test_random_traffic();

    // Wait out every owed response, then a full walk for anything stray.
    drain_requests();
    repeat (WALK_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[fixed_block_pool_allocator_core] OK");
    end else begin
      $display("[fixed_block_pool_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/fbpa_pkg.sv
sv/fbpa_list_ram.sv
sv/fbpa_cfg_regs.sv
sv/fixed_block_pool_allocator_core.sv
sv/fbpa_checker.sv
sim/fixed_block_pool_allocator_core_tb.sv
